/* rtl/core/bge_pkg.sv */
// Shared types and constants of the battery gauge: config, commands, states.
`default_nettype none
package bge_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int MV_W      = 16;
    localparam int PCT_W     = 7;
    localparam int LEVEL_W   = 2;
    localparam int FILT_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int NUM_W     = 23;  // ((v - lo) * 100) >> 16 stays below 2^23
    localparam int DIV_STEPS = 23;
    localparam int CNT_W     = 5;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    typedef enum logic [2:0] {
        REG_GAIN   = 3'd0,
        REG_ALPHA  = 3'd1,
        REG_EMPTY  = 3'd2,
        REG_FULL   = 3'd3,
        REG_CRIT   = 3'd4,
        REG_LOW    = 3'd5,
        REG_MEDIUM = 3'd6
    } reg_idx_t;

    typedef enum logic [LEVEL_W-1:0] {
        LEVEL_CRITICAL = 2'd0,
        LEVEL_LOW      = 2'd1,
        LEVEL_MEDIUM   = 2'd2,
        LEVEL_HIGH     = 2'd3
    } level_t;

    typedef struct packed {
        logic [MV_W-1:0]  divider_gain;
        logic [MV_W-1:0]  smoothing_alpha;
        logic [MV_W-1:0]  empty_mv;
        logic [MV_W-1:0]  full_mv;
        logic [PCT_W-1:0] critical_pct;
        logic [PCT_W-1:0] low_pct;
        logic [PCT_W-1:0] medium_pct;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_EMA,
        ST_UPD,
        ST_PCT,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic scale;
        logic ema;
        logic upd;
        logic pct;
        logic div_step;
        logic out_load;
    } cmd_t;

endpackage
`default_nettype wire

/* rtl/core/bge_regs.sv */
// APB configuration register file of the battery gauge.
`default_nettype none
module bge_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bge_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [bge_pkg::DATA_W-1:0]  pwdata,
    output logic      [bge_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output bge_pkg::cfg_t                    cfg
);

    bge_pkg::cfg_t cfg_reg;
    logic [2:0]    idx;
    logic          wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.divider_gain    <= 16'd8192;
            cfg_reg.smoothing_alpha <= 16'd13107;
            cfg_reg.empty_mv        <= 16'd3400;
            cfg_reg.full_mv         <= 16'd4100;
            cfg_reg.critical_pct    <= 7'd15;
            cfg_reg.low_pct         <= 7'd40;
            cfg_reg.medium_pct      <= 7'd70;
        end else if (wr_en) begin
            unique case (idx)
                bge_pkg::REG_GAIN:   cfg_reg.divider_gain    <= pwdata[15:0];
                bge_pkg::REG_ALPHA:  cfg_reg.smoothing_alpha <= pwdata[15:0];
                bge_pkg::REG_EMPTY:  cfg_reg.empty_mv        <= pwdata[15:0];
                bge_pkg::REG_FULL:   cfg_reg.full_mv         <= pwdata[15:0];
                bge_pkg::REG_CRIT:   cfg_reg.critical_pct    <= pwdata[6:0];
                bge_pkg::REG_LOW:    cfg_reg.low_pct         <= pwdata[6:0];
                bge_pkg::REG_MEDIUM: cfg_reg.medium_pct      <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            bge_pkg::REG_GAIN:   prdata = {16'h0, cfg_reg.divider_gain};
            bge_pkg::REG_ALPHA:  prdata = {16'h0, cfg_reg.smoothing_alpha};
            bge_pkg::REG_EMPTY:  prdata = {16'h0, cfg_reg.empty_mv};
            bge_pkg::REG_FULL:   prdata = {16'h0, cfg_reg.full_mv};
            bge_pkg::REG_CRIT:   prdata = {25'h0, cfg_reg.critical_pct};
            bge_pkg::REG_LOW:    prdata = {25'h0, cfg_reg.low_pct};
            bge_pkg::REG_MEDIUM: prdata = {25'h0, cfg_reg.medium_pct};
            default:             prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/bge_ctrl.sv */
// Sequencer of the battery gauge: handshakes, step order, divide count.
`default_nettype none
module bge_ctrl (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    output bge_pkg::cmd_t cmd
);

    bge_pkg::state_t          state_reg, state_next;
    logic [bge_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      valid_reg, valid_next;

    assign m_tvalid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bge_pkg::ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            bge_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = bge_pkg::ST_SCALE;
                end
            end
            bge_pkg::ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = bge_pkg::ST_EMA;
            end
            bge_pkg::ST_EMA: begin
                cmd.ema    = 1'b1;
                state_next = bge_pkg::ST_UPD;
            end
            bge_pkg::ST_UPD: begin
                cmd.upd    = 1'b1;
                state_next = bge_pkg::ST_PCT;
            end
            bge_pkg::ST_PCT: begin
                cmd.pct    = 1'b1;
                cnt_next   = '0;
                state_next = bge_pkg::ST_DIV;
            end
            bge_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == bge_pkg::CNT_W'(bge_pkg::DIV_STEPS - 1)) begin
                    state_next = bge_pkg::ST_DONE;
                end
            end
            bge_pkg::ST_DONE: begin
                // hold the result until the output register is free
                if (!valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = bge_pkg::ST_IDLE;
                end
            end
            default: state_next = bge_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/bge_dpath.sv */
// Datapath of the battery gauge: scale, EMA filter, percent divide, output word.
`default_nettype none
module bge_dpath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire bge_pkg::cfg_t                 cfg,
    input  wire bge_pkg::cmd_t                 cmd,
    input  wire logic [bge_pkg::SAMPLE_W-1:0]  sample,
    output logic      [31:0]                   out_word
);

    logic [bge_pkg::SAMPLE_W-1:0] sample_reg;
    logic [bge_pkg::FILT_W-1:0]   cur_reg;
    logic signed [49:0]           prod_reg;
    logic [bge_pkg::FILT_W-1:0]   filt_reg, filt_next;
    logic                         seeded_reg;
    logic                         gt_reg;
    logic [bge_pkg::NUM_W-1:0]    quo_reg;
    logic [bge_pkg::MV_W-1:0]     rem_reg;
    logic [31:0]                  out_reg;

    logic [27:0]                  scaled_in;
    logic signed [32:0]           diff;
    logic signed [49:0]           prod;
    logic signed [49:0]           acc;
    logic [bge_pkg::FILT_W-1:0]   lo;
    logic [bge_pkg::FILT_W-1:0]   vdiff;
    logic [38:0]                  num_full;
    logic [bge_pkg::MV_W-1:0]     span;
    logic [bge_pkg::MV_W:0]       trial;
    logic                         take;
    logic [bge_pkg::PCT_W-1:0]    pct;
    bge_pkg::level_t              level;
    logic                         crit;

    assign out_word = out_reg;

    // battery mv in Q16.16: pin mv times Q4.12 gain, shifted up by four
    assign scaled_in = {16'h0, sample_reg} * {12'h0, cfg.divider_gain};

    // acc = f * 2^16 + alpha * (cur - f)
    assign diff = $signed({1'b0, cur_reg}) - $signed({1'b0, filt_reg});
    assign prod = $signed({1'b0, cfg.smoothing_alpha}) * diff;
    assign acc  = $signed({2'b00, filt_reg, 16'h0}) + prod_reg;
    assign filt_next = seeded_reg ? acc[47:16] : cur_reg;

    // the span carries 16 zero fraction bits, so drop them from the numerator
    assign lo       = {cfg.empty_mv, 16'h0};
    assign vdiff    = filt_reg - lo;
    assign num_full = {7'h0, vdiff} * 39'd100;
    assign span     = cfg.full_mv - cfg.empty_mv;

    assign trial = {rem_reg, quo_reg[bge_pkg::NUM_W-1]};
    assign take  = trial >= {1'b0, span};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seeded_reg <= 1'b0;
            filt_reg   <= '0;
        end else if (cmd.upd) begin
            seeded_reg <= 1'b1;
            filt_reg   <= filt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            sample_reg <= sample;
        end
        if (cmd.scale) begin
            cur_reg <= {scaled_in, 4'h0};
        end
        if (cmd.ema) begin
            prod_reg <= prod;
        end
        if (cmd.pct) begin
            gt_reg  <= filt_reg > lo;
            quo_reg <= num_full[38:16];
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= take ? bge_pkg::MV_W'(trial - {1'b0, span})
                            : bge_pkg::MV_W'(trial);
            quo_reg <= {quo_reg[bge_pkg::NUM_W-2:0], take};
        end
        if (cmd.out_load) begin
            out_reg <= {6'h0, crit, level, pct, filt_reg[31:16]};
        end
    end

    always_comb begin
        if (!gt_reg) begin
            pct = '0;
        end else if (cfg.full_mv <= cfg.empty_mv) begin
            pct = bge_pkg::PCT_FULL;
        end else if (quo_reg > bge_pkg::NUM_W'(bge_pkg::PCT_FULL)) begin
            pct = bge_pkg::PCT_FULL;
        end else begin
            pct = quo_reg[bge_pkg::PCT_W-1:0];
        end

        if (pct >= cfg.medium_pct) begin
            level = bge_pkg::LEVEL_HIGH;
        end else if (pct >= cfg.low_pct) begin
            level = bge_pkg::LEVEL_MEDIUM;
        end else if (pct >= cfg.critical_pct) begin
            level = bge_pkg::LEVEL_LOW;
        end else begin
            level = bge_pkg::LEVEL_CRITICAL;
        end

        crit = pct <= cfg.critical_pct;
    end

endmodule
`default_nettype wire

/* rtl/core/battery_gauge_ema_level_top.sv */
// Top level of the EMA-filtered battery percentage gauge.
//
//  channel   direction  handshake          payload
//  s_ (in)   slave      s_tvalid/s_tready  s_tdata: sample_mv
//  m_ (out)  master     m_tvalid/m_tready  m_tdata: battery_mv, charge_pct, level, critical
//  apb       slave      psel/penable       seven config registers at 4*i
//
// Each word runs from acceptance to the result register through the gain multiply,
// the EMA multiply, the filter update and the percent multiply, then the
// one-bit-per-cycle restoring divide by the voltage span, and the output load.
// A new word is taken once the sequencer is back in idle, even while a result
// still waits in the output register; the next result waits for it to drain.
// aresetn is synchronous, active low: it restores register defaults and unseeds the filter.
`default_nettype none
module battery_gauge_ema_level_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // sample_mv [11:0], zero [15:12]
    input  wire logic [15:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // battery_mv [15:0], charge_pct [22:16], charge_level [24:23],
    // is_critical [25], zero [31:26]
    output logic      [31:0] m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    bge_pkg::cfg_t cfg;
    bge_pkg::cmd_t cmd;

    // register file: defaults on reset, written in the APB access phase
    bge_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: advance one step per cycle, hold in done until output frees
    bge_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // datapath: scale, filter, percent divide and output register
    bge_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .sample   (s_tdata[11:0]),
        .out_word (m_tdata)
    );

`ifndef SYNTHESIS
    // only one word in the datapath at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a word is still in work");

    // never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("output register loaded while a result waits");

    // percentage is clamped
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[22:16] <= 7'd100))
        else $error("charge percentage above one hundred");

    // a result appears only in the cycle after an output load
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid ##1 m_tvalid) |-> $past(cmd.out_load))
        else $error("result valid without an output load");
`endif

endmodule
`default_nettype wire
